FILE: rtl/grbi_pkg.sv
// Shared types and constants for the gyro rate and bias integrator.
package grbi_pkg;

    // Calibration run length and counter width
    localparam int CALIB_SAMPLES = 100;
    localparam int CALIB_CNT_W   = 11;

    // Scaling constants
    localparam logic [15:0]        FULL_SCALE = 16'd32767;
    localparam logic signed [19:0] DEG_SCALE  = 20'sd360000;   // 1000 * 360
    localparam logic [15:0]        DEG_DIV    = 16'd310;

    // Shared divider geometry: 40-bit magnitude, two quotient bits per cycle
    localparam int DIV_MAG_W   = 40;
    localparam int DIV_DVS_W   = 16;
    localparam int DIV_STEP    = 2;
    localparam int DIV_CYCLES  = DIV_MAG_W / DIV_STEP;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    // Configuration register indexes
    localparam logic REG_GAIN        = 1'b0;
    localparam logic REG_SAMPLE_RATE = 1'b1;

    localparam logic [15:0] GAIN_RESET        = 16'd4363;
    localparam logic [15:0] SAMPLE_RATE_RESET = 16'd1000;

    // Commands
    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_CALIB   = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] raw_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [28:0] rate;
        logic signed [31:0] integral;
        logic               calib_done;
    } out_item_t;

    typedef struct packed {
        logic                        start;
        logic signed [DIV_MAG_W:0]   dividend;
        logic [DIV_DVS_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                        busy;
        logic                        done;
        logic signed [DIV_MAG_W:0]   quotient;
    } div_rsp_t;

endpackage

FILE: rtl/grbi_div.sv
// Signed iterative radix-4 restoring divider, quotient truncated toward zero.
module grbi_div (
    input  logic               clk,
    input  logic               rst_n,
    input  grbi_pkg::div_req_t req,
    output grbi_pkg::div_rsp_t rsp
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [grbi_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                                neg_reg, neg_next;
    logic [grbi_pkg::DIV_MAG_W-1:0]      dvd_reg, dvd_next;
    logic [grbi_pkg::DIV_DVS_W-1:0]      rem_reg, rem_next;
    logic [grbi_pkg::DIV_DVS_W-1:0]      dvs_reg, dvs_next;

    logic signed [grbi_pkg::DIV_MAG_W:0] abs_dvd;
    logic [grbi_pkg::DIV_MAG_W-1:0]      step_dvd;
    logic [grbi_pkg::DIV_DVS_W-1:0]      step_rem;
    logic [grbi_pkg::DIV_DVS_W:0]        trial;
    logic [grbi_pkg::DIV_MAG_W:0]        mag_q;

    always_comb
    begin
        step_dvd = dvd_reg;
        step_rem = rem_reg;
        trial    = '0;
        for (int i = 0; i < grbi_pkg::DIV_STEP; i++)
        begin
            trial = {step_rem, step_dvd[grbi_pkg::DIV_MAG_W-1]};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial    = trial - {1'b0, dvs_reg};
                step_dvd = {step_dvd[grbi_pkg::DIV_MAG_W-2:0], 1'b1};
            end
            else
            begin
                step_dvd = {step_dvd[grbi_pkg::DIV_MAG_W-2:0], 1'b0};
            end
            step_rem = trial[grbi_pkg::DIV_DVS_W-1:0];
        end
    end

    assign abs_dvd = req.dividend[grbi_pkg::DIV_MAG_W] ? -req.dividend : req.dividend;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = req.dividend[grbi_pkg::DIV_MAG_W];
            dvd_next  = abs_dvd[grbi_pkg::DIV_MAG_W-1:0];
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = step_dvd;
            rem_next = step_rem;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == grbi_pkg::DIV_CNT_W'(grbi_pkg::DIV_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // Restore the sign on the magnitude quotient
    assign mag_q        = {1'b0, dvd_reg};
    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(mag_q) : $signed(mag_q);

endmodule

FILE: rtl/gyro_rate_bias_integrator_core.sv
// Gyro bias calibration, rate scaling and angle integration around a shared divider.
// Measure transaction: three divisions on the shared divider, plus two multiply steps and
//   one output step; next transaction accepted the cycle after the result is loaded.
// Calibration transaction: an accumulate step and an output step, plus one division
//   when it completes a run.
// Reset clears the sequencer, bias, rate, integral, calibration sum and count, and
//   loads the register defaults; the output register drops valid.
module gyro_rate_bias_integrator_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  grbi_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output grbi_pkg::out_item_t out_data,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_CAL_ADD   = 13'b0000000000010,
        S_CAL_GO    = 13'b0000000000100,
        S_CAL_WAIT  = 13'b0000000001000,
        S_MUL_GAIN  = 13'b0000000010000,
        S_FS_GO     = 13'b0000000100000,
        S_FS_WAIT   = 13'b0000001000000,
        S_MUL_DEG   = 13'b0000010000000,
        S_DEG_GO    = 13'b0000100000000,
        S_DEG_WAIT  = 13'b0001000000000,
        S_RATE_GO   = 13'b0010000000000,
        S_RATE_WAIT = 13'b0100000000000,
        S_EMIT      = 13'b1000000000000
    } state_t;

    localparam logic [grbi_pkg::CALIB_CNT_W-1:0] CalibCnt =
        grbi_pkg::CALIB_CNT_W'(grbi_pkg::CALIB_SAMPLES);

    state_t                               state_reg, state_next;
    logic [15:0]                          gain_reg, sr_reg;
    logic                                 cmd_reg;
    logic signed [15:0]                   raw_reg;
    logic signed [15:0]                   bias_reg, bias_next;
    logic signed [28:0]                   rate_reg, rate_next;
    logic signed [31:0]                   angle_reg, angle_next;
    logic signed [31:0]                   csum_reg, csum_next;
    logic [grbi_pkg::CALIB_CNT_W-1:0]     ccnt_reg, ccnt_next;
    logic                                 cdone_reg, cdone_next;
    logic signed [grbi_pkg::DIV_MAG_W:0]  work_reg, work_next;
    logic                                 out_valid_reg;
    grbi_pkg::out_item_t                  out_reg;

    logic                                 accept;
    logic                                 out_free;
    logic signed [16:0]                   diff;
    logic signed [17:0]                   neg_diff;
    logic signed [34:0]                   prod_gain;
    logic signed [38:0]                   prod_deg;
    logic [grbi_pkg::CALIB_CNT_W-1:0]     ccnt_inc;
    logic [15:0]                          sr_eff;
    grbi_pkg::div_req_t                   div_req;
    grbi_pkg::div_rsp_t                   div_rsp;

    grbi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Scaling datapath: one multiply per step, registered into work_reg
    assign diff      = 17'(raw_reg) - 17'(bias_reg);
    assign neg_diff  = -18'(diff);
    assign prod_gain = 35'(neg_diff) * 35'($signed({1'b0, gain_reg}));
    assign prod_deg  = 39'($signed(work_reg[18:0])) * 39'(grbi_pkg::DEG_SCALE);
    assign ccnt_inc  = ccnt_reg + 1'b1;
    assign sr_eff    = (sr_reg == 16'd0) ? 16'd1 : sr_reg;

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = work_reg;
        div_req.divisor  = grbi_pkg::FULL_SCALE;
        unique case (state_reg)
            S_CAL_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = (grbi_pkg::DIV_MAG_W + 1)'(csum_reg);
                div_req.divisor  = 16'(grbi_pkg::CALIB_SAMPLES);
            end
            S_FS_GO:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = grbi_pkg::FULL_SCALE;
            end
            S_DEG_GO:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = grbi_pkg::DEG_DIV;
            end
            S_RATE_GO:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = sr_eff;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        bias_next  = bias_reg;
        rate_next  = rate_reg;
        angle_next = angle_reg;
        csum_next  = csum_reg;
        ccnt_next  = ccnt_reg;
        cdone_next = cdone_reg;
        work_next  = work_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cdone_next = 1'b0;
                    state_next = (in_data.command == grbi_pkg::CMD_CALIB) ? S_CAL_ADD
                                                                          : S_MUL_GAIN;
                end
            end
            S_CAL_ADD:
            begin
                csum_next = csum_reg + 32'(raw_reg);
                ccnt_next = ccnt_inc;
                state_next = (ccnt_inc >= CalibCnt) ? S_CAL_GO : S_EMIT;
            end
            S_CAL_GO:
            begin
                state_next = S_CAL_WAIT;
            end
            S_CAL_WAIT:
            begin
                if (div_rsp.done)
                begin
                    bias_next  = div_rsp.quotient[15:0];
                    angle_next = '0;
                    csum_next  = '0;
                    ccnt_next  = '0;
                    cdone_next = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_MUL_GAIN:
            begin
                work_next  = (grbi_pkg::DIV_MAG_W + 1)'(prod_gain);
                state_next = S_FS_GO;
            end
            S_FS_GO:
            begin
                state_next = S_FS_WAIT;
            end
            S_FS_WAIT:
            begin
                if (div_rsp.done)
                begin
                    work_next  = div_rsp.quotient;
                    state_next = S_MUL_DEG;
                end
            end
            S_MUL_DEG:
            begin
                work_next  = (grbi_pkg::DIV_MAG_W + 1)'(prod_deg);
                state_next = S_DEG_GO;
            end
            S_DEG_GO:
            begin
                state_next = S_DEG_WAIT;
            end
            S_DEG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    work_next  = div_rsp.quotient;
                    rate_next  = div_rsp.quotient[28:0];
                    state_next = S_RATE_GO;
                end
            end
            S_RATE_GO:
            begin
                state_next = S_RATE_WAIT;
            end
            S_RATE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    angle_next = angle_reg + div_rsp.quotient[31:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // Hold until the output register can take the result
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain_reg      <= grbi_pkg::GAIN_RESET;
            sr_reg        <= grbi_pkg::SAMPLE_RATE_RESET;
            bias_reg      <= '0;
            rate_reg      <= '0;
            angle_reg     <= '0;
            csum_reg      <= '0;
            ccnt_reg      <= '0;
            cdone_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bias_reg  <= bias_next;
            rate_reg  <= rate_next;
            angle_reg <= angle_next;
            csum_reg  <= csum_next;
            ccnt_reg  <= ccnt_next;
            cdone_reg <= cdone_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    grbi_pkg::REG_GAIN:        gain_reg <= cfg_data;
                    grbi_pkg::REG_SAMPLE_RATE: sr_reg   <= cfg_data;
                    default:                   gain_reg <= gain_reg;
                endcase
            end
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (accept)
        begin
            cmd_reg <= in_data.command;
            raw_reg <= in_data.raw_sample;
        end
        if (state_reg == S_EMIT && out_free)
        begin
            out_reg.rate       <= rate_reg;
            out_reg.integral   <= angle_reg;
            out_reg.calib_done <= cdone_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A new division is only launched on an idle divider
    assert property (@(posedge clk) disable iff (!rst_n) div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A measure transaction must not be routed into the calibration path
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CAL_ADD) |-> (cmd_reg == grbi_pkg::CMD_CALIB))
        else $error("calibration step for a measure transaction");

    // Between transactions the calibration count stays below the run length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (ccnt_reg < CalibCnt))
        else $error("calibration count not restarted");

    // A completed calibration run reports a cleared integral
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.calib_done) |-> (out_data.integral == 32'sd0))
        else $error("integral not cleared at end of calibration");

endmodule
